FILE: hdl/assert_macros.svh
// Assertion macros shared by the controller modules.
// Every property is sampled on the rising clock and ignored while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold whenever reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must never be seen while reset is low.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: hdl/pfa_pkg.sv
// Shared types, register indexes and saturation helper for the PID controller.
// Used by the bit-serial divider and by the top level; depends on nothing.
package pfa_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic [2:0]         csr_index_type;

   localparam word_type WORD_MAX = 32'sh7fffffff;
   localparam word_type WORD_MIN = 32'sh80000000;
   localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
   localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

   // Configuration register indexes.
   localparam csr_index_type REG_PROP_GAIN     = 3'd0;
   localparam csr_index_type REG_INTEG_GAIN    = 3'd1;
   localparam csr_index_type REG_DERIV_GAIN    = 3'd2;
   localparam csr_index_type REG_FF_GAIN       = 3'd3;
   localparam csr_index_type REG_FF_RATE_GAIN  = 3'd4;
   localparam csr_index_type REG_SAMPLE_PERIOD = 3'd5;
   localparam csr_index_type REG_OUT_MAX       = 3'd6;
   localparam csr_index_type REG_OUT_MIN       = 3'd7;

   // Request to the divider: quotient is (num * 2^FRAC_BITS) / den.
   typedef struct packed {
      logic               start;
      logic signed [32:0] num;
      word_type           den;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quot;
   } div_rsp_type;

   function automatic word_type sat_word(input logic signed [63:0] v);
      word_type r;
      if (v > WIDE_MAX) begin
         r = WORD_MAX;
      end else if (v < WIDE_MIN) begin
         r = WORD_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/pid_feedforward_antiwindup.sv
// PID controller with setpoint feedforward and integral anti-windup, signed fixed point.
// Depends on pfa_pkg, pfa_div and assert_macros.svh.
//
// Each request word (setpoint, measurement) yields one response word (drive). The
// block takes one word at a time and is not ready while it works on it. One 32x32
// multiplier and one bit-serial divider are shared under a small sequencer; the
// divider sets the pace, two quotients per word (setpoint rate and error
// derivative) and a third when the integral clamp acts; words are Q16.16 at the
// default FRAC_BITS. A finished response waits in an output register while the next
// request word is taken. Gains and limits are to be written through the csr port
// only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module pid_feedforward_antiwindup
   import pfa_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   // Request: setpoint [31:0], measurement [63:32]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,
   // Response: drive [31:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   // Configuration write
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_data
);

   localparam longint RstProp  = ((longint'(15) << FRAC_BITS) + 50) / 100;
   localparam longint RstInteg = longint'(1) << FRAC_BITS;
   localparam longint RstFf    = ((longint'(33) << FRAC_BITS) + 50) / 100;
   localparam longint RstDt    = ((longint'(4) << FRAC_BITS) + 50) / 100;
   localparam longint RstOmax  = ((longint'(580) << FRAC_BITS) + 50) / 100;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RATE     = 4'd1;
   localparam logic [3:0] S_RATE_W   = 4'd2;
   localparam logic [3:0] S_DE       = 4'd3;
   localparam logic [3:0] S_DE_W     = 4'd4;
   localparam logic [3:0] S_EDT_MUL  = 4'd5;
   localparam logic [3:0] S_INTEG    = 4'd6;
   localparam logic [3:0] S_KIS_MUL  = 4'd7;
   localparam logic [3:0] S_KIS      = 4'd8;
   localparam logic [3:0] S_CLAMP_W  = 4'd9;
   localparam logic [3:0] S_TERM_MUL = 4'd10;
   localparam logic [3:0] S_TERM_ACC = 4'd11;
   localparam logic [3:0] S_LIMIT    = 4'd12;
   localparam logic [3:0] S_EMIT     = 4'd13;

   localparam logic [2:0] TERM_PROP  = 3'd0;
   localparam logic [2:0] TERM_INTEG = 3'd1;
   localparam logic [2:0] TERM_DERIV = 3'd2;
   localparam logic [2:0] TERM_FF    = 3'd3;
   localparam logic [2:0] TERM_RATE  = 3'd4;

   // Configuration registers
   word_type    kp_ff, ki_ff, kd_ff, kff_ff, kfr_ff, omax_ff, omin_ff;
   logic [30:0] dt_ff;

   // Controller state and per-word working registers
   logic [3:0]         state_ff, state_in;
   logic [2:0]         term_ff;
   word_type           isum_ff, prev_err_ff, prev_sp_ff;
   word_type           sp_ff, e_ff, last_ff, rate_ff, de_ff, edt_ff, drive_ff;
   logic signed [34:0] m_ff;
   logic signed [63:0] prod_ff;
   logic               rsp_valid_ff;
   word_type           rsp_data_ff;

   word_type           req_sp, req_ms, e_in, mul_a, mul_b, dt_word, prod_q;
   logic               mul_en, out_free, kis_low, kis_high, undo;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_sp   = signed'(req_tdata[31:0]);
   assign req_ms   = signed'(req_tdata[63:32]);
   assign e_in     = sat_word(64'(req_sp) - 64'(req_ms));
   assign dt_word  = signed'({1'b0, dt_ff});
   assign prod_q   = sat_word(prod_ff >>> FRAC_BITS);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign kis_low  = prod_q < omin_ff;
   assign kis_high = prod_q > omax_ff;
   assign undo     = (m_ff > 35'(omax_ff) && e_ff > 0) || (m_ff < 35'(omin_ff) && e_ff < 0);

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pfa_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_en = 1'b0;
      mul_a  = e_ff;
      mul_b  = dt_word;
      if (state_ff == S_EDT_MUL) begin
         mul_en = 1'b1;
      end else if (state_ff == S_KIS_MUL) begin
         mul_en = 1'b1;
         mul_a  = ki_ff;
         mul_b  = isum_ff;
      end else if (state_ff == S_TERM_MUL) begin
         mul_en = 1'b1;
         case (term_ff)
            TERM_PROP:  begin mul_a = kp_ff;  mul_b = e_ff;    end
            TERM_INTEG: begin mul_a = ki_ff;  mul_b = isum_ff; end
            TERM_DERIV: begin mul_a = kd_ff;  mul_b = de_ff;   end
            TERM_FF:    begin mul_a = kff_ff; mul_b = sp_ff;   end
            TERM_RATE:  begin mul_a = kfr_ff; mul_b = rate_ff; end
            default:    begin mul_a = kp_ff;  mul_b = e_ff;    end
         endcase
      end
   end

   // Divider requests: setpoint rate, error derivative, integral clamp.
   always_comb begin
      div_req.start = 1'b0;
      div_req.num   = 33'(sp_ff) - 33'(prev_sp_ff);
      div_req.den   = dt_word;
      if (state_ff == S_RATE) begin
         div_req.start = 1'b1;
      end else if (state_ff == S_DE) begin
         div_req.start = 1'b1;
         div_req.num   = 33'(e_ff) - 33'(last_ff);
      end else if (state_ff == S_KIS && (kis_low || kis_high)) begin
         // The lower limit wins when both tests fire.
         div_req.start = 1'b1;
         div_req.num   = kis_low ? 33'(omin_ff) : 33'(omax_ff);
         div_req.den   = ki_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_RATE;
         S_RATE:     state_in = S_RATE_W;
         S_RATE_W:   if (div_rsp.done) state_in = S_DE;
         S_DE:       state_in = S_DE_W;
         S_DE_W:     if (div_rsp.done) state_in = S_EDT_MUL;
         S_EDT_MUL:  state_in = S_INTEG;
         S_INTEG:    state_in = (ki_ff != '0) ? S_KIS_MUL : S_TERM_MUL;
         S_KIS_MUL:  state_in = S_KIS;
         S_KIS:      state_in = (kis_low || kis_high) ? S_CLAMP_W : S_TERM_MUL;
         S_CLAMP_W:  if (div_rsp.done) state_in = S_TERM_MUL;
         S_TERM_MUL: state_in = S_TERM_ACC;
         S_TERM_ACC: state_in = (term_ff == TERM_RATE) ? S_LIMIT : S_TERM_MUL;
         S_LIMIT:    state_in = S_EMIT;
         S_EMIT:     if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         term_ff      <= TERM_PROP;
         isum_ff      <= '0;
         prev_err_ff  <= '0;
         prev_sp_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= 32'(RstProp);
         ki_ff        <= 32'(RstInteg);
         kd_ff        <= '0;
         kff_ff       <= 32'(RstFf);
         kfr_ff       <= '0;
         dt_ff        <= 31'(RstDt);
         omax_ff      <= 32'(RstOmax);
         omin_ff      <= 32'(-RstOmax);
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            unique case (csr_index)
               REG_PROP_GAIN:     kp_ff   <= csr_data;
               REG_INTEG_GAIN:    ki_ff   <= csr_data;
               REG_DERIV_GAIN:    kd_ff   <= csr_data;
               REG_FF_GAIN:       kff_ff  <= csr_data;
               REG_FF_RATE_GAIN:  kfr_ff  <= csr_data;
               REG_SAMPLE_PERIOD: dt_ff   <= csr_data[30:0];
               REG_OUT_MAX:       omax_ff <= csr_data;
               REG_OUT_MIN:       omin_ff <= csr_data;
            endcase
         end

         // In the emit state the output register is refilled below instead.
         if (rsp_valid_ff && rsp_tready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  sp_ff       <= req_sp;
                  e_ff        <= e_in;
                  last_ff     <= prev_err_ff;
                  prev_err_ff <= e_in;
                  term_ff     <= TERM_PROP;
                  m_ff        <= '0;
               end
            end
            S_RATE_W: begin
               if (div_rsp.done) begin
                  rate_ff    <= div_rsp.quot;
                  prev_sp_ff <= sp_ff;
               end
            end
            S_DE_W: begin
               if (div_rsp.done) de_ff <= div_rsp.quot;
            end
            S_INTEG: begin
               edt_ff  <= prod_q;
               isum_ff <= sat_word(64'(isum_ff) + 64'(prod_q));
            end
            S_CLAMP_W: begin
               if (div_rsp.done) isum_ff <= div_rsp.quot;
            end
            S_TERM_ACC: begin
               m_ff <= m_ff + 35'(prod_q);
               if (term_ff != TERM_RATE) term_ff <= term_ff + 1'b1;
            end
            S_LIMIT: begin
               // Take the integration step back when the output saturates with the error.
               if (undo) isum_ff <= sat_word(64'(isum_ff) - 64'(edt_ff));
               if (m_ff > 35'(omax_ff)) begin
                  drive_ff <= omax_ff;
               end else if (m_ff < 35'(omin_ff)) begin
                  drive_ff <= omin_ff;
               end else begin
                  drive_ff <= m_ff[31:0];
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= drive_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   `ASSERT_CLK(a_done_when_waiting,
      div_rsp.done |-> (state_ff == S_RATE_W || state_ff == S_DE_W || state_ff == S_CLAMP_W),
      "divider result arrived outside a wait state")
   `ASSERT_CLK(a_emit_holds, (state_ff == S_EMIT && rsp_valid_ff && !rsp_tready) |=>
      (state_ff == S_EMIT && $stable(rsp_data_ff)), "response overwritten before it was taken")
   `ASSERT_CLK(a_term_range, term_ff <= TERM_RATE, "term counter ran past the last term")
   `ASSERT_CLK(a_clamp_needs_gain, (state_ff == S_KIS_MUL) |-> (ki_ff != '0),
      "integral clamp entered with zero integral gain")

endmodule

FILE: hdl/pfa_div.sv
// Bit-serial restoring divider for fixed-point quotients, one quotient bit a cycle.
// Depends on pfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfa_div
   import pfa_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int NumW = 33 + FRAC_BITS;
   localparam int CntW = $clog2(NumW);

   logic                busy_ff;
   logic                fin_ff;
   logic                done_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [NumW-1:0]     num_ff;
   logic [NumW-1:0]     quo_ff;
   logic [31:0]         rem_ff;
   logic [31:0]         den_ff;
   logic                neg_ff;
   word_type            quot_ff;

   logic [32:0]         num_mag;
   logic [31:0]         den_mag;
   logic [32:0]         rem_shift;
   logic                fits;
   logic signed [63:0]  mag_wide;

   assign num_mag   = div_req.num[32] ? 33'(-div_req.num) : 33'(div_req.num);
   assign den_mag   = div_req.den[31] ? 32'(-div_req.den) : 32'(div_req.den);
   assign rem_shift = {rem_ff, num_ff[NumW-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign mag_wide  = signed'(64'(quo_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (div_req.start) begin
            neg_ff <= div_req.num[32] ^ div_req.den[31];
            num_ff <= {num_mag, {FRAC_BITS{1'b0}}};
            den_ff <= den_mag;
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= CntW'(NumW - 1);
            if (div_req.den == '0) begin
               // Division by zero answers with the limit in the dividend's direction, or zero for a zero dividend.
               done_ff <= 1'b1;
               if (div_req.num[32]) begin
                  quot_ff <= WORD_MIN;
               end else if (div_req.num != '0) begin
                  quot_ff <= WORD_MAX;
               end else begin
                  quot_ff <= '0;
               end
            end else begin
               busy_ff <= 1'b1;
               done_ff <= 1'b0;
            end
         end else if (busy_ff) begin
            done_ff <= 1'b0;
            rem_ff <= fits ? 32'(rem_shift - {1'b0, den_ff}) : rem_shift[31:0];
            quo_ff <= {quo_ff[NumW-2:0], fits};
            num_ff <= {num_ff[NumW-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
            quot_ff <= sat_word(neg_ff ? -mag_wide : mag_wide);
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   `ASSERT_NEVER(a_start_idle, div_req.start && (busy_ff || fin_ff), "divider restarted while busy")
   `ASSERT_CLK(a_done_pulse, done_ff |=> !done_ff, "divider done held for two cycles")
   `ASSERT_CLK(a_fin_after_busy, $rose(fin_ff) |-> $past(busy_ff), "divider finished without iterating")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the PID controller with feedforward and anti-windup.
// Depends on pfa_pkg and pid_feedforward_antiwindup; needs no files or arguments.
// A scoreboard class predicts each drive word; plain tasks drive the stream ports.
`timescale 1ns / 1ps

module testbench;
   import pfa_pkg::*;

   localparam int     FRAC        = 16;
   localparam longint UNIT        = 64'sd1 <<< FRAC;
   localparam int     HOLD_CYCLES = 600;
   localparam int     PHASES      = 9;
   localparam int     PHASE_WORDS = 125;

   // Tracks the controller state and queues the drive word due for every request word.
   class drive_tracker;
      longint   kp, ki, kd, kff, kfr, dt, lim_hi, lim_lo;
      longint   integ, err_prev, sp_prev;
      word_type drive_due[$];
      int       errors;
      int       checked;

      function new();
         kp       = 9830;
         ki       = 65536;
         kd       = 0;
         kff      = 21627;
         kfr      = 0;
         dt       = 2621;
         lim_hi   = 380109;
         lim_lo   = -380109;
         integ    = 0;
         err_prev = 0;
         sp_prev  = 0;
         errors   = 0;
         checked  = 0;
      endfunction

      function longint clamp_word(longint v);
         if (v > WIDE_MAX) begin
            return WIDE_MAX;
         end else if (v < WIDE_MIN) begin
            return WIDE_MIN;
         end
         return v;
      endfunction

      // The shift of a signed product rounds toward minus infinity.
      function longint qmul(longint a, longint b);
         longint p;
         p = a * b;
         return clamp_word(p >>> FRAC);
      endfunction

      function longint qdiv(longint a, longint b);
         if (b == 0) begin
            if (a > 0) begin
               return WIDE_MAX;
            end else if (a < 0) begin
               return WIDE_MIN;
            end
            return 0;
         end
         return clamp_word((a * UNIT) / b);
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            REG_PROP_GAIN:     kp = longint'($signed(v));
            REG_INTEG_GAIN:    ki = longint'($signed(v));
            REG_DERIV_GAIN:    kd = longint'($signed(v));
            REG_FF_GAIN:       kff = longint'($signed(v));
            REG_FF_RATE_GAIN:  kfr = longint'($signed(v));
            REG_SAMPLE_PERIOD: dt = {33'b0, v[30:0]};
            REG_OUT_MAX:       lim_hi = longint'($signed(v));
            REG_OUT_MIN:       lim_lo = longint'($signed(v));
            default: ;
         endcase
      endfunction

      function void note_sample(word_type sp, word_type ms);
         longint s, m, rate, last, err, de, ki_s, raw;
         s = sp;
         m = ms;
         rate = qdiv(s - sp_prev, dt);
         sp_prev = s;
         last = err_prev;
         err = clamp_word(s - m);
         err_prev = err;
         integ = clamp_word(integ + qmul(err, dt));
         de = qdiv(err - last, dt);
         // Both limit tests see the product taken before clamping, so the lower one wins.
         if (ki != 0) begin
            ki_s = qmul(ki, integ);
            if (ki_s > lim_hi) integ = qdiv(lim_hi, ki);
            if (ki_s < lim_lo) integ = qdiv(lim_lo, ki);
         end
         raw = qmul(kp, err) + qmul(ki, integ) + qmul(kd, de) + qmul(kff, s) +
               qmul(kfr, rate);
         if ((raw > lim_hi && err > 0) || (raw < lim_lo && err < 0)) begin
            integ = clamp_word(integ - qmul(err, dt));
         end
         if (raw > lim_hi) begin
            raw = lim_hi;
         end else if (raw < lim_lo) begin
            raw = lim_lo;
         end
         drive_due.push_back(word_type'(raw));
      endfunction

      function void check_drive(logic [31:0] got);
         word_type want;
         if (drive_due.size() == 0) begin
            $display("%0t: drive word %h arrived with none expected", $time, got);
            errors++;
            return;
         end
         want = drive_due.pop_front();
         checked++;
         if (got !== want) begin
            $display("%0t: drive mismatch, expected %0d (%h), actual %0d (%h)",
                     $time, want, want, $signed(got), got);
            errors++;
         end
      endfunction

      function int pending();
         return drive_due.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;   // setpoint [31:0], measurement [63:32]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;        // drive [31:0]
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_PROP_GAIN;
   logic [31:0]   csr_data = '0;

   drive_tracker tracker = new();

   bit sender_quiet = 1'b0;
   bit sink_quiet = 1'b0;
   bit hold_sink = 1'b0;
   int plant_sp = 0;
   int plant_meas = 0;
   int words_sent = 0;
   int settings_loaded = 0;

   pid_feedforward_antiwindup i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Timed out with %0d drive words outstanding.", tracker.pending());
      $display("== FAIL ==");
      $finish;
   end

   // Valid is left high when the next word follows with no gap.
   task automatic send_sample(input word_type sp, input word_type ms);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ms, sp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_sample(sp, ms);
      words_sent++;
   endtask

   // Registers are only written once every drive word due has come back.
   task automatic load_settings(input logic [31:0] kp, ki, kd, kff, kfr, period, hi, lo);
      logic [31:0] value [8];
      value[REG_PROP_GAIN]     = kp;
      value[REG_INTEG_GAIN]    = ki;
      value[REG_DERIV_GAIN]    = kd;
      value[REG_FF_GAIN]       = kff;
      value[REG_FF_RATE_GAIN]  = kfr;
      value[REG_SAMPLE_PERIOD] = period;
      value[REG_OUT_MAX]       = hi;
      value[REG_OUT_MIN]       = lo;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= value[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.set_reg(csr_index_type'(i), value[i]);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   function automatic word_type corner_value();
      case ($urandom_range(0, 4))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return 32'sd0;
         3: return 32'sd1;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      int v;
      case ($urandom_range(0, 6))
         0: return 32'h0;
         1: return $urandom();
         2: return 32'h7fffffff;
         3: return 32'h80000000;
         default: begin
            v = $urandom_range(0, 262144);
            return v - 131072;
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return $urandom();
         2: return 32'h7fffffff;
         3: return 32'hffffffff;
         default: return $urandom_range(1, 65536);
      endcase
   endfunction

   // Most random words follow a slow first-order plant chasing a stepped setpoint.
   task automatic send_random();
      int mode, step, noise, t;
      word_type sp, ms;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         if ($urandom_range(0, 9) == 0) begin
            t = $urandom_range(0, 1048576);
            plant_sp = t - 524288;
         end
         step = (plant_sp - plant_meas) >>> 3;
         noise = $urandom_range(0, 2048);
         noise = noise - 1024;
         plant_meas = plant_meas + step + noise;
         sp = plant_sp;
         ms = plant_meas;
      end else if (mode < 9) begin
         sp = $urandom();
         ms = $urandom();
      end else begin
         sp = corner_value();
         ms = corner_value();
      end
      send_sample(sp, ms);
   endtask

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = sink_quiet ? 0 : $urandom_range(0, 8);
         if (hold_sink) begin
            hold_sink = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         tracker.check_drive(rsp_tdata);
      end
   end

   initial begin
      int lim;
      logic [31:0] hi, lo;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings from reset: saturated errors and the integration being taken back.
      send_sample(32'sd0, 32'sd0);
      send_sample(WORD_MAX, WORD_MIN);
      send_sample(WORD_MIN, WORD_MAX);
      send_sample(WORD_MAX, WORD_MAX);
      send_sample(WORD_MIN, WORD_MIN);
      send_sample(32'sd65536, 32'sd0);
      send_sample(-32'sd196608, 32'sd131072);

      // Zero sample period and zero integral gain.
      load_settings(32'h10000, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0,
                    WORD_MAX, WORD_MIN);
      send_sample(32'sd65536, 32'sd0);
      send_sample(32'sd0, 32'sd65536);
      send_sample(32'sd0, 32'sd65536);
      send_sample(32'sd0, 32'sd0);

      // Crossed limits: the integral clamp fires both ways and the lower limit wins.
      load_settings(32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h10000,
                    -32'sd5, 32'sd5);
      send_sample(32'sd0, 32'sd0);
      send_sample(32'sd0, 32'sd327680);
      send_sample(32'sd0, -32'sd327680);
      send_sample(32'sd0, 32'sd327680);
      send_sample(32'sd65536, 32'sd0);

      // Extreme gains and period, widest limits.
      load_settings(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, WORD_MAX, WORD_MIN);
      send_sample(WORD_MAX, WORD_MIN);
      send_sample(WORD_MIN, WORD_MAX);
      send_sample(32'sd0, 32'sd0);
      load_settings(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'hffffffff, WORD_MAX, WORD_MIN);
      send_sample(WORD_MIN, 32'sd0);
      send_sample(WORD_MAX, 32'sd0);
      send_sample(32'sd1, -32'sd1);

      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 4))
            0: begin
               hi = WORD_MAX;
               lo = WORD_MIN;
            end
            1: begin
               hi = $urandom();
               lo = $urandom();
            end
            2: begin
               lim = $urandom_range(0, 1048576);
               hi = -lim;
               lo = lim;
            end
            default: begin
               lim = $urandom_range(1, 1048576);
               hi = lim;
               lim = $urandom_range(1, 1048576);
               lo = -lim;
            end
         endcase
         load_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                       pick_period(), hi, lo);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0) begin
               sender_quiet = ($urandom_range(0, 3) == 0);
               sink_quiet = ($urandom_range(0, 3) == 0);
            end
            // One long hold on the response side while words keep coming, to back the block up.
            if (phase == 3 && n == 10) begin
               sender_quiet = 1'b1;
               hold_sink = 1'b1;
            end
            send_random();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d request words and checked %0d drive words under %0d settings,",
               words_sent, tracker.checked, settings_loaded);
      $display("including zero period, crossed limits and extreme gains; %0d errors.",
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
